FILE: sv/ebt_pkg.sv
`default_nettype none

package ebt_pkg;

   localparam int BASE_W = 16;
   localparam int CNT_W  = 8;
   localparam int DEFAULT_MAX_TIMEOUT_MS = 60000;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [2:0] REG_EXP_MODE     = 3'd0;
   localparam logic [2:0] REG_CAP_ENABLE   = 3'd1;
   localparam logic [2:0] REG_CAP_MS       = 3'd2;
   localparam logic [2:0] REG_LIMIT_ENABLE = 3'd3;
   localparam logic [2:0] REG_LIMIT        = 3'd4;

   localparam logic [BASE_W-1:0] CAP_RESET   = '1;
   localparam logic [CNT_W-1:0]  COUNT_SAT   = '1;

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_START    = 2'd1,
      CMD_STOP     = 2'd2,
      CMD_SET_BASE = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type           command;
      logic [BASE_W-1:0] new_base_ms;
   } req_type;

   typedef struct packed {
      logic              expired;
      logic              running_now;
      logic [CNT_W-1:0]  expiry_total;
      logic [BASE_W-1:0] loaded_timeout_ms;
      logic              base_error;
   } rsp_type;

   typedef struct packed {
      logic              exp_mode;
      logic              cap_enable;
      logic [BASE_W-1:0] cap_ms;
      logic              limit_enable;
      logic [CNT_W-1:0]  limit;
   } cfg_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic step;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic need_double;
      logic step_done;
      logic rsp_full;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: sv/ebt_csr.sv
`default_nettype none

module ebt_csr (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          psel,
   input  wire                          penable,
   input  wire                          pwrite,
   input  wire [ebt_pkg::CSR_AW-1:0]    paddr,
   input  wire [ebt_pkg::CSR_DW-1:0]    pwdata,
   output logic [ebt_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready,
   output ebt_pkg::cfg_type             cfg
);
   import ebt_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign reg_index = paddr[4:2];
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_EXP_MODE:     cfg_in.exp_mode     = pwdata[0];
            REG_CAP_ENABLE:   cfg_in.cap_enable   = pwdata[0];
            REG_CAP_MS:       cfg_in.cap_ms       = pwdata[BASE_W-1:0];
            REG_LIMIT_ENABLE: cfg_in.limit_enable = pwdata[0];
            REG_LIMIT:        cfg_in.limit        = pwdata[CNT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_EXP_MODE:     prdata = CSR_DW'(cfg_ff.exp_mode);
         REG_CAP_ENABLE:   prdata = CSR_DW'(cfg_ff.cap_enable);
         REG_CAP_MS:       prdata = CSR_DW'(cfg_ff.cap_ms);
         REG_LIMIT_ENABLE: prdata = CSR_DW'(cfg_ff.limit_enable);
         REG_LIMIT:        prdata = CSR_DW'(cfg_ff.limit);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.exp_mode     <= 1'b0;
         cfg_ff.cap_enable   <= 1'b0;
         cfg_ff.cap_ms       <= CAP_RESET;
         cfg_ff.limit_enable <= 1'b0;
         cfg_ff.limit        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/ebt_ctrl.sv
`default_nettype none

module ebt_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  ebt_pkg::dp_status_type status,
   output ebt_pkg::dp_cmd_type    cmd
);
   import ebt_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_DOUBLE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      can_take;

   // A new beat may enter while the previous result is leaving.
   assign can_take  = (state_ff == ST_IDLE) && !status.rsp_full;
   assign req_stall = !can_take;

   always_comb begin
      cmd.load = can_take && req_valid;
      cmd.step = (state_ff == ST_DOUBLE);
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load && status.need_double) begin
               state_in = ST_DOUBLE;
            end
         end
         ST_DOUBLE: begin
            if (status.step_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/ebt_datapath.sv
`default_nettype none

module ebt_datapath #(
   parameter int MAX_TIMEOUT_MS = ebt_pkg::DEFAULT_MAX_TIMEOUT_MS
) (
   input  wire                     clock,
   input  wire                     reset,
   input  ebt_pkg::cfg_type        cfg,
   input  ebt_pkg::req_type        req_data,
   input  wire                     rsp_stall,
   output logic                    rsp_valid,
   output ebt_pkg::rsp_type        rsp_data,
   input  ebt_pkg::dp_cmd_type     cmd,
   output ebt_pkg::dp_status_type  status
);
   import ebt_pkg::*;

   localparam int TW = BASE_W + 1;
   localparam logic [TW-1:0]     MAX_T  = TW'(MAX_TIMEOUT_MS);
   localparam logic [BASE_W-1:0] MAX_16 = BASE_W'(MAX_TIMEOUT_MS);

   logic [BASE_W-1:0] remaining_ff, remaining_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              running_ff, running_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [TW-1:0]     t_ff, t_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [CNT_W-1:0]  cnt_inc;
   logic              run_keep;
   logic              expiring;
   logic              loop_end;
   logic [TW-1:0]     t_dbl;
   logic              capped;
   logic [BASE_W-1:0] dbl_result;

   assign cnt_inc  = (count_ff == COUNT_SAT) ? count_ff : count_ff + 1'b1;
   assign run_keep = !cfg.limit_enable || (cnt_inc <= cfg.limit);
   assign expiring = (req_data.command == CMD_TICK) && running_ff && (remaining_ff <= 1);

   // One doubling per cycle; the loop ends on count exhausted, the maximum
   // reached or the cap exceeded. A zero base can never grow, so it ends the loop at once.
   assign loop_end   = (n_ff == '0) || (t_ff >= MAX_T) || (t_ff == '0);
   assign t_dbl      = {t_ff[BASE_W-1:0], 1'b0};
   assign capped     = cfg.cap_enable && (t_dbl > {1'b0, cfg.cap_ms});
   assign dbl_result = loop_end ? ((t_ff > MAX_T) ? MAX_16 : t_ff[BASE_W-1:0]) : cfg.cap_ms;

   assign status.need_double = expiring && run_keep && cfg.exp_mode;
   assign status.step_done   = loop_end || capped;
   assign status.rsp_full    = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      remaining_in = remaining_ff;
      count_in     = count_ff;
      running_in   = running_ff;
      base_in      = base_ff;
      t_in         = t_ff;
      n_in         = n_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         rsp_in.expired           = 1'b0;
         rsp_in.running_now       = running_ff;
         rsp_in.expiry_total      = count_ff;
         rsp_in.loaded_timeout_ms = '0;
         rsp_in.base_error        = 1'b0;
         rsp_valid_in             = !status.need_double;
         unique case (req_data.command)
            CMD_TICK: begin
               if (running_ff) begin
                  if (!expiring) begin
                     remaining_in = remaining_ff - 1'b1;
                  end else begin
                     count_in              = cnt_inc;
                     running_in            = run_keep;
                     rsp_in.expired        = 1'b1;
                     rsp_in.running_now    = run_keep;
                     rsp_in.expiry_total   = cnt_inc;
                     if (!run_keep) begin
                        remaining_in = '0;
                     end else if (cfg.exp_mode) begin
                        t_in = {1'b0, base_ff};
                        n_in = cnt_inc;
                     end else begin
                        remaining_in             = base_ff;
                        rsp_in.loaded_timeout_ms = base_ff;
                     end
                  end
               end
            end
            CMD_START: begin
               running_in               = 1'b1;
               count_in                 = '0;
               remaining_in             = base_ff;
               rsp_in.running_now       = 1'b1;
               rsp_in.expiry_total      = '0;
               rsp_in.loaded_timeout_ms = base_ff;
            end
            CMD_STOP: begin
               running_in          = 1'b0;
               count_in            = '0;
               remaining_in        = '0;
               rsp_in.running_now  = 1'b0;
               rsp_in.expiry_total = '0;
            end
            CMD_SET_BASE: begin
               if ({1'b0, req_data.new_base_ms} > MAX_T) begin
                  rsp_in.base_error = 1'b1;
               end else begin
                  base_in = req_data.new_base_ms;
               end
            end
            default: rsp_in = rsp_ff;
         endcase
      end else if (cmd.step) begin
         if (status.step_done) begin
            remaining_in             = dbl_result;
            rsp_in.expired           = 1'b1;
            rsp_in.running_now       = 1'b1;
            rsp_in.expiry_total      = count_ff;
            rsp_in.loaded_timeout_ms = dbl_result;
            rsp_in.base_error        = 1'b0;
            rsp_valid_in             = 1'b1;
         end else begin
            t_in = t_dbl;
            n_in = n_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         count_ff     <= '0;
         running_ff   <= 1'b0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         remaining_ff <= remaining_in;
         count_ff     <= count_in;
         running_ff   <= running_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff   <= t_in;
      n_ff   <= n_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

FILE: sv/exponential_backoff_timer.sv
// For most commands a beat's result is valid in the cycle after it is accepted.
// A tick that expires with exponential reload runs the doubling unit, one
// doubling per cycle (at most 16 doublings), before its result is registered.
// Throughput: one beat per cycle while the result is not stalled, except during a doubling sequence.
// Reset is synchronous: timer state clears, registers return to defaults.
`default_nettype none

module exponential_backoff_timer #(
   parameter int MAX_TIMEOUT_MS = ebt_pkg::DEFAULT_MAX_TIMEOUT_MS
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  ebt_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output ebt_pkg::rsp_type            rsp_data,
   input  wire                         psel,
   input  wire                         penable,
   input  wire                         pwrite,
   input  wire [ebt_pkg::CSR_AW-1:0]   paddr,
   input  wire [ebt_pkg::CSR_DW-1:0]   pwdata,
   output logic [ebt_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import ebt_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   ebt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ebt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   ebt_datapath #(
      .MAX_TIMEOUT_MS (MAX_TIMEOUT_MS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

endmodule

`default_nettype wire

FILE: sv/ebt_checker.sv
`default_nettype none

module ebt_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_valid,
   input wire                         req_stall,
   input ebt_pkg::req_type            req_data,
   input wire                         rsp_valid,
   input wire                         rsp_stall,
   input ebt_pkg::rsp_type            rsp_data
);
   import ebt_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result payload changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.command == CMD_STOP |=>
         rsp_valid && !rsp_data.running_now && rsp_data.expiry_total == '0)
      else $error("stop did not yield a stopped, cleared result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.running_now |-> rsp_data.loaded_timeout_ms == '0)
      else $error("timeout loaded while timer stopped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.expired && rsp_data.base_error))
      else $error("expiry and base error in one result");

endmodule

bind exponential_backoff_timer ebt_checker u_ebt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
